@@ rtl/button_debounce_click_and_rgb_pwm_defines.svh @@
// assertion macros for the button debounce and rgb pwm block
// no dependencies; included by the top level
`ifndef BUTTON_DEBOUNCE_CLICK_AND_RGB_PWM_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_AND_RGB_PWM_DEFINES_SVH
`ifndef SYNTH
`define BDRGB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BDRGB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BDRGB_ASSERT(lbl, prop, msg)
`define BDRGB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ rtl/bdrgb_pkg.sv @@
// shared types and constants for the button debounce and rgb pwm block
// no dependencies
`timescale 1ns / 1ps

package bdrgb_pkg;

    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DIM_ENABLE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_ENABLE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_DUTY      = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_DUTY    = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_DUTY     = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE      = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 8'd7;

    localparam logic [7:0]  PWM_PERIOD_RST = 8'd5;
    localparam logic [15:0] DEBOUNCE_RST   = 16'd10;
    localparam logic [15:0] LONG_PRESS_RST = 16'd500;

    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_CLICK = 2'd1;
    localparam logic [1:0] EVT_LONG  = 2'd2;

    typedef struct packed {
        logic [31:0] tick_time;
        logic        button_raw;
    } in_t;

    typedef struct packed {
        logic       red_on;
        logic       green_on;
        logic       blue_on;
        logic       button_level;
        logic [1:0] button_event;
    } out_t;

    typedef struct packed {
        logic        dim_enable;
        logic        button_enable;
        logic [7:0]  pwm_period;
        logic [7:0]  red_duty;
        logic [7:0]  green_duty;
        logic [7:0]  blue_duty;
        logic [15:0] debounce_ticks;
        logic [15:0] long_press_ticks;
    } cfg_t;

endpackage

@@ rtl/bdrgb_pwm.sv @@
// three-channel soft pwm: epoch and led state registers with next-led logic
// depends on bdrgb_pkg
`timescale 1ns / 1ps

module bdrgb_pwm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [31:0]       tick_time,
    input  bdrgb_pkg::cfg_t   cfg,
    output logic [2:0]        led_next
);

    logic [31:0] pwm_epoch_reg, pwm_epoch_next;
    logic [2:0]  led_states_reg;
    logic [31:0] elapsed;
    logic        restart;
    logic [31:0] el;

    always_comb begin
        elapsed        = tick_time - pwm_epoch_reg;
        restart        = elapsed > {24'd0, cfg.pwm_period};
        el             = restart ? 32'd0 : elapsed;
        pwm_epoch_next = pwm_epoch_reg;
        led_next       = led_states_reg;
        if (cfg.dim_enable) begin
            pwm_epoch_next = restart ? tick_time : pwm_epoch_reg;
            led_next[0]    = el < {24'd0, cfg.red_duty};
            led_next[1]    = el < {24'd0, cfg.green_duty};
            led_next[2]    = el < {24'd0, cfg.blue_duty};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_epoch_reg  <= 32'd0;
            led_states_reg <= 3'd0;
        end else if (advance) begin
            pwm_epoch_reg  <= pwm_epoch_next;
            led_states_reg <= led_next;
        end
    end

endmodule

@@ rtl/bdrgb_button.sv @@
// button debounce and click / long-press classification
// depends on bdrgb_pkg
`timescale 1ns / 1ps

module bdrgb_button (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [31:0]       tick_time,
    input  logic              button_raw,
    input  bdrgb_pkg::cfg_t   cfg,
    output logic              level_next,
    output logic [1:0]        event_next
);

    logic        stable_level_reg;
    logic [31:0] last_agree_reg, last_agree_next;
    logic [31:0] press_start_reg, press_start_next;
    logic        settled;
    logic        differs;
    logic [31:0] press_len;
    logic [31:0] long_ticks;

    always_comb begin
        settled          = (tick_time - last_agree_reg) > {16'd0, cfg.debounce_ticks};
        differs          = button_raw != stable_level_reg;
        press_len        = tick_time - press_start_reg;
        long_ticks       = {16'd0, cfg.long_press_ticks};
        level_next       = stable_level_reg;
        last_agree_next  = last_agree_reg;
        press_start_next = press_start_reg;
        event_next       = bdrgb_pkg::EVT_NONE;
        if (cfg.button_enable) begin
            if (settled && differs) begin
                level_next = button_raw;
                if (!button_raw) begin
                    press_start_next = tick_time;
                end else if (press_len < long_ticks) begin
                    event_next = bdrgb_pkg::EVT_CLICK;
                end else if (press_len > long_ticks) begin
                    event_next = bdrgb_pkg::EVT_LONG;
                end
            end else if (!differs) begin
                last_agree_next = tick_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_level_reg <= 1'b1;
            last_agree_reg   <= 32'd0;
            press_start_reg  <= 32'd0;
        end else if (advance) begin
            stable_level_reg <= level_next;
            last_agree_reg   <= last_agree_next;
            press_start_reg  <= press_start_next;
        end
    end

endmodule

@@ rtl/button_debounce_click_and_rgb_pwm.sv @@
// top level: button debounce with click classification and rgb soft pwm
// input channel s_*, result channel m_*, register write channel cfg_*
// a beat on s_data carries one tick: 32-bit time and the raw active-low level
// a beat on m_data carries the three led states, the debounced level and event
// cfg_index selects the register (0..7), other indexes are dropped
// cfg_ready is always high; the user writes registers only while the block is
// idle, which the block itself does not enforce; an accepted beat lands in an
// input register; once the output register is free or m_ready is high, the pwm
// and debounce logic run on it and load the result into the output register
// throughput: one beat per cycle while m_ready is high, set by the single
// logic pass between the input and output registers, which also updates the
// pwm and button state; when m_ready is low the result holds and the input
// register still fills; s_ready drops only when both registers are full
// reset clears both valid flags and restores the register and state defaults
`timescale 1ns / 1ps

`include "button_debounce_click_and_rgb_pwm_defines.svh"

module button_debounce_click_and_rgb_pwm (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bdrgb_pkg::in_t                      s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bdrgb_pkg::out_t                     m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdrgb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                         cfg_data
);

    bdrgb_pkg::cfg_t cfg_reg;
    bdrgb_pkg::in_t  in_data_reg;
    logic            in_valid_reg;
    bdrgb_pkg::out_t out_data_reg, out_data_next;
    logic            out_valid_reg;
    logic            advance;
    logic [2:0]      led_next;
    logic            level_next;
    logic [1:0]      event_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dim_enable       <= 1'b0;
            cfg_reg.button_enable    <= 1'b0;
            cfg_reg.pwm_period       <= bdrgb_pkg::PWM_PERIOD_RST;
            cfg_reg.red_duty         <= 8'd0;
            cfg_reg.green_duty       <= 8'd0;
            cfg_reg.blue_duty        <= 8'd0;
            cfg_reg.debounce_ticks   <= bdrgb_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= bdrgb_pkg::LONG_PRESS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bdrgb_pkg::REG_DIM_ENABLE:    cfg_reg.dim_enable       <= cfg_data[0];
                bdrgb_pkg::REG_BUTTON_ENABLE: cfg_reg.button_enable    <= cfg_data[0];
                bdrgb_pkg::REG_PWM_PERIOD:    cfg_reg.pwm_period       <= cfg_data[7:0];
                bdrgb_pkg::REG_RED_DUTY:      cfg_reg.red_duty         <= cfg_data[7:0];
                bdrgb_pkg::REG_GREEN_DUTY:    cfg_reg.green_duty       <= cfg_data[7:0];
                bdrgb_pkg::REG_BLUE_DUTY:     cfg_reg.blue_duty        <= cfg_data[7:0];
                bdrgb_pkg::REG_DEBOUNCE:      cfg_reg.debounce_ticks   <= cfg_data[15:0];
                bdrgb_pkg::REG_LONG_PRESS:    cfg_reg.long_press_ticks <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    bdrgb_pwm u_pwm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .tick_time (in_data_reg.tick_time),
        .cfg       (cfg_reg),
        .led_next  (led_next)
    );

    bdrgb_button u_button (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .tick_time  (in_data_reg.tick_time),
        .button_raw (in_data_reg.button_raw),
        .cfg        (cfg_reg),
        .level_next (level_next),
        .event_next (event_next)
    );

    always_comb begin
        out_data_next.red_on       = led_next[0];
        out_data_next.green_on     = led_next[1];
        out_data_next.blue_on      = led_next[2];
        out_data_next.button_level = level_next;
        out_data_next.button_event = event_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    `BDRGB_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")
    `BDRGB_ASSERT(a_no_repeat, (m_valid && m_ready && !advance) |=> !m_valid, "result repeated")
    `BDRGB_ASSERT(a_event_on_release, (m_valid && m_data.button_event != bdrgb_pkg::EVT_NONE) |-> m_data.button_level, "event while pressed")
    `BDRGB_ASSERT(a_disabled_no_event, (advance && !cfg_reg.button_enable) |=> (m_data.button_event == bdrgb_pkg::EVT_NONE), "event with button disabled")

endmodule

@@ tb/sv/bdrgb_status_checker.sv @@
// result checker for the button debounce and rgb pwm block
// keeps its own copy of the pwm and debounce state, predicts each result beat
// and compares it with the block's output in order; depends on bdrgb_pkg
`timescale 1ns / 1ps

module bdrgb_status_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  bdrgb_pkg::in_t                    s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  bdrgb_pkg::out_t                   m_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bdrgb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                       cfg_data,
    output int unsigned                       errors,
    output int unsigned                       pending,
    output int unsigned                       results_seen,
    output int unsigned                       clicks,
    output int unsigned                       long_presses
);

    bdrgb_pkg::cfg_t regs;
    logic [31:0]     pwm_epoch;
    logic [2:0]      led_states;
    logic            stable_level;
    logic [31:0]     last_agree;
    logic [31:0]     press_start;
    bdrgb_pkg::out_t status_due[$];

    task automatic report_mismatch(input string field, input logic [1:0] got,
                                   input logic [1:0] want);
        errors++;
        if (errors <= 100)
            $display("[%0t] result beat %0d: %s got %0d want %0d",
                     $realtime, results_seen, field, got, want);
    endtask

    task automatic restore_defaults();
        regs                  = '0;
        regs.pwm_period       = bdrgb_pkg::PWM_PERIOD_RST;
        regs.debounce_ticks   = bdrgb_pkg::DEBOUNCE_RST;
        regs.long_press_ticks = bdrgb_pkg::LONG_PRESS_RST;
        pwm_epoch    = '0;
        led_states   = '0;
        stable_level = 1'b1;
        last_agree   = '0;
        press_start  = '0;
        status_due.delete();
    endtask

    task automatic write_reg(input logic [bdrgb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        case (idx)
            bdrgb_pkg::REG_DIM_ENABLE:    regs.dim_enable       = data[0];
            bdrgb_pkg::REG_BUTTON_ENABLE: regs.button_enable    = data[0];
            bdrgb_pkg::REG_PWM_PERIOD:    regs.pwm_period       = data[7:0];
            bdrgb_pkg::REG_RED_DUTY:      regs.red_duty         = data[7:0];
            bdrgb_pkg::REG_GREEN_DUTY:    regs.green_duty       = data[7:0];
            bdrgb_pkg::REG_BLUE_DUTY:     regs.blue_duty        = data[7:0];
            bdrgb_pkg::REG_DEBOUNCE:      regs.debounce_ticks   = data[15:0];
            bdrgb_pkg::REG_LONG_PRESS:    regs.long_press_ticks = data[15:0];
            default: ;
        endcase
    endtask

    function automatic bdrgb_pkg::out_t next_status(input bdrgb_pkg::in_t beat);
        logic [31:0]     elapsed;
        logic [31:0]     since_agree;
        logic [31:0]     held;
        logic [1:0]      evt;
        bdrgb_pkg::out_t r;
        evt = bdrgb_pkg::EVT_NONE;
        if (regs.dim_enable) begin
            elapsed = beat.tick_time - pwm_epoch;
            if (elapsed > {24'd0, regs.pwm_period}) begin
                pwm_epoch = beat.tick_time;
                elapsed   = '0;
            end
            led_states = {elapsed < {24'd0, regs.blue_duty},
                          elapsed < {24'd0, regs.green_duty},
                          elapsed < {24'd0, regs.red_duty}};
        end
        if (regs.button_enable) begin
            since_agree = beat.tick_time - last_agree;
            if (since_agree > {16'd0, regs.debounce_ticks}
                    && beat.button_raw != stable_level) begin
                stable_level = beat.button_raw;
                if (!stable_level) begin
                    press_start = beat.tick_time;
                end else begin
                    held = beat.tick_time - press_start;
                    if (held < {16'd0, regs.long_press_ticks})
                        evt = bdrgb_pkg::EVT_CLICK;
                    else if (held > {16'd0, regs.long_press_ticks})
                        evt = bdrgb_pkg::EVT_LONG;
                end
            end else if (beat.button_raw == stable_level) begin
                last_agree = beat.tick_time;
            end
        end
        r.red_on       = led_states[0];
        r.green_on     = led_states[1];
        r.blue_on      = led_states[2];
        r.button_level = stable_level;
        r.button_event = evt;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        bdrgb_pkg::out_t want;
        if (!aresetn) begin
            restore_defaults();
            pending = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    report_mismatch("beat with nothing pending", m_data.button_event,
                                    bdrgb_pkg::EVT_NONE);
                end else begin
                    want = status_due.pop_front();
                    if (m_data.red_on !== want.red_on)
                        report_mismatch("red_on", {1'b0, m_data.red_on},
                                        {1'b0, want.red_on});
                    if (m_data.green_on !== want.green_on)
                        report_mismatch("green_on", {1'b0, m_data.green_on},
                                        {1'b0, want.green_on});
                    if (m_data.blue_on !== want.blue_on)
                        report_mismatch("blue_on", {1'b0, m_data.blue_on},
                                        {1'b0, want.blue_on});
                    if (m_data.button_level !== want.button_level)
                        report_mismatch("button_level", {1'b0, m_data.button_level},
                                        {1'b0, want.button_level});
                    if (m_data.button_event !== want.button_event)
                        report_mismatch("button_event", m_data.button_event,
                                        want.button_event);
                    if (want.button_event == bdrgb_pkg::EVT_CLICK)
                        clicks++;
                    if (want.button_event == bdrgb_pkg::EVT_LONG)
                        long_presses++;
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                status_due.push_back(next_status(s_data));
            pending = status_due.size();
        end
    end

endmodule

@@ tb/sv/tb_button_debounce_click_and_rgb_pwm.sv @@
// testbench top for the button debounce and rgb pwm block: clock, reset,
// tick and register stimulus with random idling, and the final verdict
// depends on bdrgb_pkg, bdrgb_status_checker and the block itself
`timescale 1ns / 1ps

module tb_button_debounce_click_and_rgb_pwm;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    bdrgb_pkg::in_t                    s_data;
    logic                              m_valid;
    logic                              m_ready;
    bdrgb_pkg::out_t                   m_data;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [bdrgb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                       cfg_data;

    int unsigned errors;
    int unsigned pending;
    int unsigned results_seen;
    int unsigned clicks;
    int unsigned long_presses;

    logic        src_gaps;
    logic        sink_stalls;
    int unsigned hold_cycles;
    logic [31:0] now;
    logic        want_level;
    int unsigned run_left;
    int unsigned step_max;
    int unsigned span_max;
    int unsigned ticks_sent;
    int unsigned settings_used;

    button_debounce_click_and_rgb_pwm DUT (.*);

    bdrgb_status_checker u_check (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic int unsigned gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    task automatic send_tick(input logic [31:0] t, input logic raw);
        bdrgb_pkg::in_t beat;
        beat.tick_time  = t;
        beat.button_raw = raw;
        s_data  <= beat;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        @(negedge aclk);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat (gap_len()) @(negedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [bdrgb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // press and release runs with contact bounce, plus some stray beats
    task automatic run_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_tick($urandom, 1'($urandom_range(0, 1)));
            end else begin
                if (run_left == 0) begin
                    want_level = ~want_level;
                    run_left   = $urandom_range(1, span_max);
                end
                run_left--;
                now = now + $urandom_range(0, step_max);
                send_tick(now, want_level ^ ($urandom_range(0, 7) == 0));
            end
        end
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        int unsigned n;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles != 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                stall_left  = 0;
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
                stall_left = gap_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic        dim;
        logic        btn;
        logic [7:0]  per;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] deb;
        logic [15:0] lp;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        src_gaps      = 1'b0;
        sink_stalls   = 1'b0;
        hold_cycles   = 0;
        now           = '0;
        want_level    = 1'b1;
        run_left      = 0;
        step_max      = 4;
        span_max      = 30;
        ticks_sent    = 0;
        settings_used = 4;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: dimming and button both off
        send_tick(32'd0, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b0);
        settle();

        cfg_write(bdrgb_pkg::REG_DIM_ENABLE, 32'hFFFF_FFF1);
        cfg_write(bdrgb_pkg::REG_BUTTON_ENABLE, 32'h0000_0003);
        cfg_write(bdrgb_pkg::REG_PWM_PERIOD, 32'hFFFF_FF03);
        cfg_write(bdrgb_pkg::REG_RED_DUTY, 32'h0000_0100);
        cfg_write(bdrgb_pkg::REG_GREEN_DUTY, 32'h8000_0002);
        cfg_write(bdrgb_pkg::REG_BLUE_DUTY, 32'h0000_00FF);
        cfg_write(bdrgb_pkg::REG_DEBOUNCE, 32'hFFFF_0002);
        cfg_write(bdrgb_pkg::REG_LONG_PRESS, 32'h0001_0005);
        cfg_write(8'd8, 32'hFFFF_FFFF);
        cfg_write(8'hFF, $urandom);

        // bounce, press equal to the boundary, click right after an accepted
        // change, then a long press
        send_tick(32'd100, 1'b1);
        send_tick(32'd101, 1'b0);
        send_tick(32'd103, 1'b0);
        send_tick(32'd104, 1'b0);
        send_tick(32'd108, 1'b1);
        send_tick(32'd109, 1'b1);
        send_tick(32'd112, 1'b0);
        send_tick(32'd113, 1'b1);
        send_tick(32'd114, 1'b1);
        send_tick(32'd120, 1'b0);
        send_tick(32'd121, 1'b0);
        send_tick(32'd130, 1'b1);
        settle();

        // zero period, zero debounce and zero boundary via truncated writes
        cfg_write(bdrgb_pkg::REG_PWM_PERIOD, 32'h0000_0100);
        cfg_write(bdrgb_pkg::REG_DEBOUNCE, 32'hFFFF_0000);
        cfg_write(bdrgb_pkg::REG_LONG_PRESS, 32'hABCD_0000);
        send_tick(32'd200, 1'b0);
        send_tick(32'd200, 1'b1);
        send_tick(32'd201, 1'b1);
        send_tick(32'd205, 1'b0);
        send_tick(32'd207, 1'b1);
        settle();

        // leds hold with dimming off, level holds with the button off
        cfg_write(bdrgb_pkg::REG_DIM_ENABLE, 32'hFFFF_FFFE);
        cfg_write(bdrgb_pkg::REG_RED_DUTY, 32'h0000_0055);
        send_tick(32'd300, 1'b1);
        settle();
        cfg_write(bdrgb_pkg::REG_BUTTON_ENABLE, 32'h0000_0002);
        send_tick(32'd301, 1'b0);
        send_tick(32'd302, 1'b1);

        for (int p = 0; p < 8; p++) begin
            settle();
            case (p)
                0: begin
                    dim = 1'b1; btn = 1'b1; per = 8'd255;
                    red = 8'd255; green = 8'd0; blue = 8'($urandom_range(0, 255));
                    deb = 16'hFFFF; lp = 16'hFFFF;
                    step_max = 30000; span_max = 6;
                    src_gaps = 1'b0; sink_stalls = 1'b0;
                end
                1: begin
                    dim = 1'b1; btn = 1'b1; per = 8'd1;
                    red = 8'd0; green = 8'd1; blue = 8'd2;
                    deb = 16'd0; lp = 16'd0;
                    step_max = 3; span_max = 10;
                    src_gaps = 1'b0; sink_stalls = 1'b1;
                end
                default: begin
                    dim = ($urandom_range(0, 3) != 0); btn = ($urandom_range(0, 3) != 0);
                    per = 8'($urandom_range(1, 12));
                    red = 8'($urandom_range(0, 14)); green = 8'($urandom_range(0, 14));
                    blue = 8'($urandom_range(0, 14));
                    deb = 16'($urandom_range(0, 12)); lp = 16'($urandom_range(0, 80));
                    step_max = 4; span_max = 40;
                    src_gaps = 1'($urandom_range(0, 1));
                    sink_stalls = 1'($urandom_range(0, 1));
                end
            endcase
            if (p == 2) begin
                src_gaps    = 1'b1;
                sink_stalls = 1'b1;
            end
            now = (p == 3) ? 32'hFFFF_FF00 : $urandom;
            cfg_write(bdrgb_pkg::REG_DIM_ENABLE, ($urandom << 1) | dim);
            cfg_write(bdrgb_pkg::REG_BUTTON_ENABLE, ($urandom << 1) | btn);
            cfg_write(bdrgb_pkg::REG_PWM_PERIOD, ($urandom << 8) | per);
            cfg_write(bdrgb_pkg::REG_RED_DUTY, ($urandom << 8) | red);
            cfg_write(bdrgb_pkg::REG_GREEN_DUTY, ($urandom << 8) | green);
            cfg_write(bdrgb_pkg::REG_BLUE_DUTY, ($urandom << 8) | blue);
            cfg_write(bdrgb_pkg::REG_DEBOUNCE, ($urandom << 16) | deb);
            cfg_write(bdrgb_pkg::REG_LONG_PRESS, ($urandom << 16) | lp);
            settings_used++;
            run_ticks(55);
            // long receiver hold while beats keep coming, and a full drain
            if (p == 2)
                hold_cycles = 250;
            if (p == 5)
                settle();
            run_ticks(55);
        end

        settle();
        repeat (20) @(posedge aclk);
        $display("covered %0d ticks over %0d register settings, incl. wrap and zero period",
                 ticks_sent, settings_used);
        $display("checked %0d results with %0d clicks and %0d long presses",
                 results_seen, clicks, long_presses);
        if (errors == 0) begin
            $display("PASS button_debounce_click_and_rgb_pwm");
        end else begin
            $display("FAIL button_debounce_click_and_rgb_pwm");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL button_debounce_click_and_rgb_pwm");
        $finish;
    end

endmodule
